/* rtl/core/stxfr_pkg.sv */
// shared types and constants for the nine-bit stx/etx framer
package stxfr_pkg;

  localparam int CNT_W   = 7;
  localparam int TDATA_W = 24;

  // input item kinds
  localparam logic [1:0] KIND_RX    = 2'd0;
  localparam logic [1:0] KIND_READY = 2'd1;
  localparam logic [1:0] KIND_LOAD  = 2'd2;

  // result kinds
  localparam logic [1:0] OUT_RX_BYTE   = 2'd0;
  localparam logic [1:0] OUT_TX_CHAR   = 2'd1;
  localparam logic [1:0] OUT_LOAD_RESP = 2'd2;

  // control characters
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;

  // register map, word index taken from paddr[2]
  localparam logic REG_MAX_PAYLOAD = 1'b0;
  localparam logic [CNT_W-1:0] MAX_PAYLOAD_RST = 7'd64;

  typedef struct packed {
    logic capture;
    logic commit;
    logic rd;
    logic send;
  } cmd_t;

  typedef struct packed {
    logic has_result;
    logic needs_read;
    logic last_beat;
    logic out_free;
  } sts_t;

endpackage

/* rtl/core/stxfr_ctrl.sv */
// controller state machine sequencing decode, store reads and result beats
module stxfr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  stxfr_pkg::sts_t   sts,
  output stxfr_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECODE = 4'b0010,
    ST_READ   = 4'b0100,
    ST_SEND   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    s_tready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = !rst;
        cmd.capture = s_tvalid && !rst;
        if (s_tvalid && !rst) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.needs_read) begin
          cmd.commit = 1'b1;
          state_next = ST_READ;
        end else if (!sts.has_result || sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (sts.out_free) begin
          cmd.send   = 1'b1;
          state_next = sts.last_beat ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/stxfr_dp.sv */
// datapath: item register, framing state, payload stores and result register
module stxfr_dp #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [stxfr_pkg::TDATA_W-1:0]       s_tdata,
  input  logic [1:0]                          s_tuser,
  input  stxfr_pkg::cmd_t                     cmd,
  output stxfr_pkg::sts_t                     sts,
  input  logic                                cfg_we,
  input  logic [stxfr_pkg::CNT_W-1:0]         cfg_wdata,
  output logic [stxfr_pkg::CNT_W-1:0]         max_payload,
  input  logic                                m_tready,
  output logic                                m_tvalid,
  output logic [stxfr_pkg::TDATA_W-1:0]       m_tdata,
  output logic [1:0]                          m_tuser,
  output logic                                m_tlast
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [stxfr_pkg::CNT_W-1:0] MAX_CNT = stxfr_pkg::CNT_W'(STORE_DEPTH);
  localparam logic [stxfr_pkg::CNT_W-1:0] ONE     = stxfr_pkg::CNT_W'(1);

  // held item
  logic [1:0] it_kind;
  logic [7:0] it_low;
  logic       it_ctl;
  logic [7:0] it_byte;
  logic       it_end;

  // framing state
  logic [stxfr_pkg::CNT_W-1:0] rx_fill, rx_fill_next;
  logic                        rx_active, rx_active_next;
  logic                        rx_lost, rx_lost_next;
  logic [stxfr_pkg::CNT_W-1:0] tx_load_index, tx_load_index_next;
  logic [stxfr_pkg::CNT_W-1:0] tx_length, tx_length_next;
  logic [stxfr_pkg::CNT_W-1:0] tx_position, tx_position_next;
  logic                        tx_start_sent, tx_start_sent_next;

  // run being emitted
  logic [stxfr_pkg::CNT_W-1:0] run_n, run_n_next;
  logic                        run_lost, run_lost_next;
  logic [stxfr_pkg::CNT_W-1:0] emit_idx, emit_idx_next;
  logic [stxfr_pkg::CNT_W-1:0] emit_inc;

  logic [7:0] rx_store [STORE_DEPTH];
  logic [7:0] tx_store [STORE_DEPTH];
  logic [7:0] rx_rd;
  logic [7:0] tx_rd;
  logic       rx_we;
  logic       tx_we;

  logic [stxfr_pkg::CNT_W-1:0] lim;
  logic [stxfr_pkg::CNT_W-1:0] load_inc;

  // decoded result
  logic                        dec_result;
  logic                        dec_read;
  logic [1:0]                  res_kind;
  logic [7:0]                  res_data;
  logic                        res_ninth;
  logic                        res_last;
  logic [stxfr_pkg::CNT_W-1:0] res_count;
  logic                        res_ovf;
  logic                        res_acc;

  // result register
  logic                        out_valid;
  logic                        out_load;
  logic [1:0]                  o_kind;
  logic [7:0]                  o_data;
  logic                        o_ninth;
  logic                        o_last;
  logic [stxfr_pkg::CNT_W-1:0] o_count;
  logic                        o_ovf;
  logic                        o_acc;

  assign lim      = (max_payload > MAX_CNT) ? MAX_CNT : max_payload;
  assign load_inc = tx_load_index + ONE;
  assign emit_inc = emit_idx + ONE;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_kind <= s_tuser;
      it_low  <= s_tdata[7:0];
      it_ctl  <= s_tdata[8];
      it_byte <= s_tdata[16:9];
      it_end  <= s_tdata[17];
    end
  end

  always_comb begin
    rx_fill_next       = rx_fill;
    rx_active_next     = rx_active;
    rx_lost_next       = rx_lost;
    tx_load_index_next = tx_load_index;
    tx_length_next     = tx_length;
    tx_position_next   = tx_position;
    tx_start_sent_next = tx_start_sent;
    run_n_next         = run_n;
    run_lost_next      = run_lost;
    emit_idx_next      = emit_idx;
    rx_we              = 1'b0;
    tx_we              = 1'b0;
    dec_result         = 1'b0;
    dec_read           = 1'b0;
    res_kind           = stxfr_pkg::OUT_RX_BYTE;
    res_data           = 8'h00;
    res_ninth          = 1'b0;
    res_last           = 1'b0;
    res_count          = '0;
    res_ovf            = 1'b0;
    res_acc            = 1'b0;
    unique case (it_kind)
      stxfr_pkg::KIND_RX: begin
        if (it_ctl) begin
          if (it_low == stxfr_pkg::CH_STX) begin
            rx_fill_next   = '0;
            rx_lost_next   = 1'b0;
            rx_active_next = 1'b1;
          end else if (it_low == stxfr_pkg::CH_ETX && rx_active) begin
            run_n_next    = rx_fill;
            run_lost_next = rx_lost;
            emit_idx_next = '0;
            rx_fill_next  = '0;
            rx_lost_next  = 1'b0;
            if (rx_fill == '0) begin
              dec_result = 1'b1;
              res_last   = 1'b1;
              res_ovf    = rx_lost;
            end else begin
              dec_read = 1'b1;
            end
          end
        end else if (rx_active) begin
          if (rx_fill < lim) begin
            rx_we        = 1'b1;
            rx_fill_next = rx_fill + ONE;
          end else begin
            rx_lost_next = 1'b1;
          end
        end
      end
      stxfr_pkg::KIND_READY: begin
        if (tx_length != '0) begin
          if (!tx_start_sent) begin
            dec_result         = 1'b1;
            tx_start_sent_next = 1'b1;
            res_kind           = stxfr_pkg::OUT_TX_CHAR;
            res_data           = stxfr_pkg::CH_STX;
            res_ninth          = 1'b1;
          end else if (tx_position >= tx_length) begin
            dec_result         = 1'b1;
            tx_length_next     = '0;
            tx_position_next   = '0;
            tx_start_sent_next = 1'b0;
            res_kind           = stxfr_pkg::OUT_TX_CHAR;
            res_data           = stxfr_pkg::CH_ETX;
            res_ninth          = 1'b1;
          end else begin
            dec_read = 1'b1;
          end
        end
      end
      stxfr_pkg::KIND_LOAD: begin
        dec_result = 1'b1;
        res_kind   = stxfr_pkg::OUT_LOAD_RESP;
        if (tx_length == '0) begin
          if (tx_load_index < lim) begin
            tx_we              = 1'b1;
            res_acc            = 1'b1;
            tx_load_index_next = load_inc;
            if (it_end) begin
              tx_length_next     = load_inc;
              tx_load_index_next = '0;
              tx_position_next   = '0;
              tx_start_sent_next = 1'b0;
            end
          end else begin
            tx_load_index_next = '0;
          end
        end
      end
      default: begin
        dec_result = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_fill       <= '0;
      rx_active     <= 1'b0;
      rx_lost       <= 1'b0;
      tx_load_index <= '0;
      tx_length     <= '0;
      tx_position   <= '0;
      tx_start_sent <= 1'b0;
      run_n         <= '0;
      run_lost      <= 1'b0;
      emit_idx      <= '0;
      max_payload   <= stxfr_pkg::MAX_PAYLOAD_RST;
    end else begin
      if (cfg_we) begin
        max_payload <= cfg_wdata;
      end
      if (cmd.commit) begin
        rx_fill       <= rx_fill_next;
        rx_active     <= rx_active_next;
        rx_lost       <= rx_lost_next;
        tx_load_index <= tx_load_index_next;
        tx_length     <= tx_length_next;
        tx_position   <= tx_position_next;
        tx_start_sent <= tx_start_sent_next;
        run_n         <= run_n_next;
        run_lost      <= run_lost_next;
        emit_idx      <= emit_idx_next;
      end else if (cmd.send) begin
        if (it_kind == stxfr_pkg::KIND_READY) begin
          tx_position <= tx_position + ONE;
        end else begin
          emit_idx <= emit_inc;
        end
      end
    end
  end

  // payload stores
  always_ff @(posedge clk) begin
    if (cmd.commit && rx_we) begin
      rx_store[rx_fill[AW-1:0]] <= it_low;
    end
    if (cmd.rd) begin
      rx_rd <= rx_store[emit_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && tx_we) begin
      tx_store[tx_load_index[AW-1:0]] <= it_byte;
    end
    if (cmd.rd) begin
      tx_rd <= tx_store[tx_position[AW-1:0]];
    end
  end

  assign sts.has_result = dec_result;
  assign sts.needs_read = dec_read;
  assign sts.last_beat  = (it_kind == stxfr_pkg::KIND_READY) || (emit_inc == run_n);
  assign sts.out_free   = !out_valid || m_tready;

  assign out_load = (cmd.commit && dec_result) || cmd.send;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && dec_result) begin
      o_kind  <= res_kind;
      o_data  <= res_data;
      o_ninth <= res_ninth;
      o_last  <= res_last;
      o_count <= res_count;
      o_ovf   <= res_ovf;
      o_acc   <= res_acc;
    end else if (cmd.send) begin
      o_ninth <= 1'b0;
      o_acc   <= 1'b0;
      if (it_kind == stxfr_pkg::KIND_READY) begin
        o_kind  <= stxfr_pkg::OUT_TX_CHAR;
        o_data  <= tx_rd;
        o_last  <= 1'b0;
        o_count <= '0;
        o_ovf   <= 1'b0;
      end else begin
        o_kind  <= stxfr_pkg::OUT_RX_BYTE;
        o_data  <= rx_rd;
        o_last  <= emit_inc == run_n;
        o_count <= run_n;
        o_ovf   <= run_lost;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = o_kind;
  assign m_tlast  = o_last;
  assign m_tdata  = {6'b0, o_acc, o_ovf, o_count, o_ninth, o_data};

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    rx_fill <= MAX_CNT)
    else $error("receive fill beyond store depth");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    tx_position <= tx_length)
    else $error("transmit position beyond message length");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || m_tready))
    else $error("result register overwritten before taken");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.send && it_kind == stxfr_pkg::KIND_RX) |-> (emit_idx < run_n))
    else $error("receive run emitted past its length");
`endif

endmodule

/* rtl/core/nine_bit_stx_etx_framer.sv */
// top level: stream ports, register port and controller/datapath pair
// a result beat is loaded into the output register in ST_DECODE from the held item, or by
// ST_READ and ST_SEND where a stored byte is read; a taken item with no result only returns
// the controller to ST_IDLE; a new item is taken only in ST_IDLE, once the last is through;
// etx with n bytes emits n beats via ST_READ and ST_SEND; a busy output stalls ST_SEND
// reset: synchronous rst clears all framing state and sets max_payload to 64; stores keep data
module nine_bit_stx_etx_framer #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [7:0] rx_low_bits, [8] rx_control_bit, [16:9] tx_payload_byte, [17] tx_payload_end
  input  logic [stxfr_pkg::TDATA_W-1:0] s_tdata,
  // [1:0] kind
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [7:0] data_byte, [8] ninth_bit, [15:9] payload_count, [16] overflowed, [17] accepted
  output logic [stxfr_pkg::TDATA_W-1:0] m_tdata,
  // [1:0] out_kind
  output logic [1:0]                    m_tuser,
  output logic                          m_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  stxfr_pkg::cmd_t             cmd;
  stxfr_pkg::sts_t             sts;
  logic                        cfg_we;
  logic [stxfr_pkg::CNT_W-1:0] max_payload;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == stxfr_pkg::REG_MAX_PAYLOAD);
  assign prdata = (paddr[2] == stxfr_pkg::REG_MAX_PAYLOAD) ? 32'(max_payload) : 32'h0;

  stxfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stxfr_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_wdata   (pwdata[stxfr_pkg::CNT_W-1:0]),
    .max_payload (max_payload),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule
